// ===== sv/tspc_pkg.sv =====
// shared types and constants for the train speed pi power controller
// used by tspc_ctrl, tspc_datapath and train_speed_pi_power_controller
package tspc_pkg;

  // default parameter values
  localparam int unsigned DEF_POWER_LIMIT    = 120000;
  localparam int unsigned DEF_GAIN_FRAC_BITS = 16;

  // field widths
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned GAIN_W  = 32;
  localparam int unsigned PER_W   = 16;
  localparam int unsigned POWER_W = 17;
  localparam int unsigned KPH_W   = 17;
  localparam int unsigned ERR_W   = 18;
  localparam int unsigned INTEG_W = 48;
  localparam int unsigned TOTAL_W = 82;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // 1.60934 in q16
  localparam logic [MUL_A_W-1:0] KPH_PER_MPH = 33'd105470;

  // divide by 2000 as shift by 4 then multiply by 2^37/125 with one correction
  localparam int unsigned         RECIP_SHIFT = 37;
  localparam logic [MUL_A_W-1:0] RECIP_125   = 33'd1099511627;
  localparam logic [30:0]        DIV_125     = 31'd125;

  // register reset value
  localparam logic [PER_W-1:0] PERIOD_RESET = 16'd100;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_PERIOD_MS  = 2'd2
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_MUL_A,
    ST_ERR,
    ST_MUL_PER,
    ST_MUL_REC,
    ST_CORR,
    ST_INTEG,
    ST_MUL_KP,
    ST_MUL_KIL,
    ST_MUL_KIH,
    ST_SUM,
    ST_CLAMP
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_T,
    OP_MUL_A,
    OP_ERR,
    OP_MUL_PER,
    OP_MUL_REC,
    OP_CORR,
    OP_INTEG,
    OP_MUL_KP,
    OP_MUL_KIL,
    OP_MUL_KIH,
    OP_SUM,
    OP_CLAMP
  } op_t;

  typedef struct packed {
    logic accept;
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ===== sv/tspc_datapath.sv =====
// datapath: config registers, shared multiplier, integrator, door state, result register
// depends on tspc_pkg
module tspc_datapath #(
  parameter int unsigned POWER_LIMIT    = tspc_pkg::DEF_POWER_LIMIT,
  parameter int unsigned GAIN_FRAC_BITS = tspc_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tspc_pkg::cmd_t                cmd,
  output tspc_pkg::status_t             status,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [tspc_pkg::GAIN_W-1:0]   cfg_data,
  input  logic [tspc_pkg::SPEED_W-1:0]  target_speed,
  input  logic [tspc_pkg::SPEED_W-1:0]  actual_speed,
  input  logic [tspc_pkg::SPEED_W-1:0]  authority,
  input  logic                          stop_request,
  input  logic [1:0]                    door_side,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [tspc_pkg::POWER_W-1:0]  power_watts,
  output logic                          left_open,
  output logic                          right_open
);

  localparam int unsigned SHIFT = GAIN_FRAC_BITS + 8;
  localparam logic [tspc_pkg::TOTAL_W-1:0] THRESH =
    (tspc_pkg::TOTAL_W'(POWER_LIMIT) + 1'b1) << SHIFT;
  localparam logic signed [tspc_pkg::INTEG_W-1:0] INTEG_CLAMP =
    tspc_pkg::INTEG_W'(POWER_LIMIT) << 8;
  localparam logic signed [tspc_pkg::INTEG_W:0] INTEG_MAX =
    {2'b00, {(tspc_pkg::INTEG_W-1){1'b1}}};

  // configuration registers
  logic [tspc_pkg::GAIN_W-1:0] prop_gain;
  logic [tspc_pkg::GAIN_W-1:0] integ_gain;
  logic [tspc_pkg::PER_W-1:0]  period_ms;

  // per-beat operands
  logic [tspc_pkg::SPEED_W-1:0] tgt;
  logic [tspc_pkg::SPEED_W-1:0] act;
  logic                         auth_zero;

  // working registers
  logic signed [tspc_pkg::PROD_W-1:0]  prod;
  logic [tspc_pkg::KPH_W-1:0]          tkph;
  logic signed [tspc_pkg::ERR_W-1:0]   err;
  logic [tspc_pkg::ERR_W-1:0]          mag;
  logic                                sum_neg;
  logic [29:0]                         div_y;
  logic signed [24:0]                  delta;
  logic signed [tspc_pkg::TOTAL_W-1:0] total;

  // controller state
  logic signed [tspc_pkg::ERR_W-1:0]   prev_error;
  logic signed [tspc_pkg::INTEG_W-1:0] integrator;
  logic                                stop_pending;
  logic                                left_door;
  logic                                right_door;

  // shared multiplier
  logic signed [tspc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tspc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [tspc_pkg::PROD_W-1:0]  mul_p;

  // combinational helpers
  logic [33:0]                         kph_rnd;
  logic [tspc_pkg::KPH_W-1:0]          akph;
  logic signed [tspc_pkg::ERR_W-1:0]   err_next;
  logic signed [tspc_pkg::ERR_W:0]     sum;
  logic [tspc_pkg::ERR_W:0]            sum_abs;
  logic [23:0]                         q0;
  logic [30:0]                         rem;
  logic [23:0]                         quo;
  logic signed [tspc_pkg::INTEG_W:0]   acc;
  logic signed [tspc_pkg::INTEG_W-1:0] acc_sat;
  logic                                sp;
  logic [tspc_pkg::TOTAL_W-1:0]        pwr_shift;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      tspc_pkg::OP_MUL_T: begin
        mul_a = tspc_pkg::KPH_PER_MPH;
        mul_b = {16'b0, tgt};
      end
      tspc_pkg::OP_MUL_A: begin
        mul_a = tspc_pkg::KPH_PER_MPH;
        mul_b = {16'b0, act};
      end
      tspc_pkg::OP_MUL_PER: begin
        mul_a = {17'b0, period_ms};
        mul_b = {14'b0, mag};
      end
      tspc_pkg::OP_MUL_REC: begin
        mul_a = tspc_pkg::RECIP_125;
        mul_b = {2'b0, prod[33:4]};
      end
      tspc_pkg::OP_MUL_KP: begin
        mul_a = {1'b0, prop_gain};
        mul_b = {{(tspc_pkg::MUL_B_W-tspc_pkg::ERR_W){err[tspc_pkg::ERR_W-1]}}, err};
      end
      tspc_pkg::OP_MUL_KIL: begin
        mul_a = {1'b0, integ_gain};
        mul_b = {8'b0, integrator[23:0]};
      end
      tspc_pkg::OP_MUL_KIH: begin
        mul_a = {1'b0, integ_gain};
        mul_b = {{8{integrator[tspc_pkg::INTEG_W-1]}}, integrator[47:24]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // speed conversion rounding, error and trapezoid sum
  assign kph_rnd  = prod[33:0] + 34'd32768;
  assign akph     = kph_rnd[32:16];
  assign err_next = tspc_pkg::ERR_W'($signed({1'b0, tkph})) -
                    tspc_pkg::ERR_W'($signed({1'b0, akph}));
  assign sum      = {err_next[tspc_pkg::ERR_W-1], err_next} +
                    {prev_error[tspc_pkg::ERR_W-1], prev_error};
  assign sum_abs  = sum[tspc_pkg::ERR_W] ? (~sum + 1'b1) : sum;

  // quotient correction for the divide by 2000
  assign q0  = prod[60:37];
  assign rem = {1'b0, div_y} - (31'(q0) * tspc_pkg::DIV_125);
  assign quo = q0 + 24'(rem >= tspc_pkg::DIV_125);

  // saturating integrator sum
  assign acc = {integrator[tspc_pkg::INTEG_W-1], integrator} +
               (tspc_pkg::INTEG_W+1)'(delta);
  always_comb begin
    if (acc > INTEG_MAX) begin
      acc_sat = INTEG_MAX[tspc_pkg::INTEG_W-1:0];
    end else if (acc < -INTEG_MAX) begin
      acc_sat = -INTEG_MAX[tspc_pkg::INTEG_W-1:0];
    end else begin
      acc_sat = acc[tspc_pkg::INTEG_W-1:0];
    end
  end

  assign pwr_shift = total >> SHIFT;
  assign sp        = stop_pending | stop_request;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      period_ms  <= tspc_pkg::PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tspc_pkg::REG_PROP_GAIN:  prop_gain  <= cfg_data;
        tspc_pkg::REG_INTEG_GAIN: integ_gain <= cfg_data;
        tspc_pkg::REG_PERIOD_MS:  period_ms  <= cfg_data[tspc_pkg::PER_W-1:0];
        default: ;
      endcase
    end
  end

  // stop latch and doors, updated when a beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_pending <= 1'b0;
      left_door    <= 1'b0;
      right_door   <= 1'b0;
    end else if (cmd.accept) begin
      if (actual_speed != '0) begin
        stop_pending <= sp;
        left_door    <= 1'b0;
        right_door   <= 1'b0;
      end else if (sp) begin
        stop_pending <= 1'b0;
        left_door    <= left_door | door_side[0];
        right_door   <= right_door | door_side[1];
      end
    end
  end

  // beat operands
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tgt       <= target_speed;
      act       <= actual_speed;
      auth_zero <= (authority == '0);
    end
  end

  // step registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      tspc_pkg::OP_MUL_T: begin
        prod <= mul_p;
      end
      tspc_pkg::OP_MUL_A: begin
        tkph <= akph;
        prod <= mul_p;
      end
      tspc_pkg::OP_ERR: begin
        err     <= err_next;
        mag     <= sum_abs[tspc_pkg::ERR_W-1:0];
        sum_neg <= sum[tspc_pkg::ERR_W];
      end
      tspc_pkg::OP_MUL_PER: begin
        prod <= mul_p;
      end
      tspc_pkg::OP_MUL_REC: begin
        div_y <= prod[33:4];
        prod  <= mul_p;
      end
      tspc_pkg::OP_CORR: begin
        delta <= sum_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      end
      tspc_pkg::OP_MUL_KP: begin
        prod <= mul_p;
      end
      tspc_pkg::OP_MUL_KIL: begin
        total <= tspc_pkg::TOTAL_W'(prod);
        prod  <= mul_p;
      end
      tspc_pkg::OP_MUL_KIH: begin
        total <= total + tspc_pkg::TOTAL_W'(prod);
        prod  <= mul_p;
      end
      tspc_pkg::OP_SUM: begin
        total <= total + (tspc_pkg::TOTAL_W'(prod) <<< 24);
      end
      default: ;
    endcase
  end

  // integrator and previous error
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
      prev_error <= '0;
    end else if (cmd.op == tspc_pkg::OP_INTEG) begin
      integrator <= acc_sat;
      prev_error <= err;
    end else if (cmd.out_load) begin
      if (auth_zero || total[tspc_pkg::TOTAL_W-1]) begin
        integrator <= '0;
      end else if (total >= THRESH) begin
        integrator <= INTEG_CLAMP;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      left_open  <= left_door;
      right_open <= right_door;
      if (auth_zero || total[tspc_pkg::TOTAL_W-1]) begin
        power_watts <= '0;
      end else if (total >= THRESH) begin
        power_watts <= tspc_pkg::POWER_W'(POWER_LIMIT);
      end else begin
        power_watts <= pwr_shift[tspc_pkg::POWER_W-1:0];
      end
    end
  end

  assign status.out_busy = out_valid & ~out_ready;

endmodule

// ===== sv/tspc_ctrl.sv =====
// sequencer for one control tick through the shared multiplier datapath
// depends on tspc_pkg
module tspc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tspc_pkg::status_t  status,
  output tspc_pkg::cmd_t     cmd
);

  tspc_pkg::state_t state;
  tspc_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tspc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tspc_pkg::ST_IDLE:    if (in_valid) state_next = tspc_pkg::ST_MUL_T;
      tspc_pkg::ST_MUL_T:   state_next = tspc_pkg::ST_MUL_A;
      tspc_pkg::ST_MUL_A:   state_next = tspc_pkg::ST_ERR;
      tspc_pkg::ST_ERR:     state_next = tspc_pkg::ST_MUL_PER;
      tspc_pkg::ST_MUL_PER: state_next = tspc_pkg::ST_MUL_REC;
      tspc_pkg::ST_MUL_REC: state_next = tspc_pkg::ST_CORR;
      tspc_pkg::ST_CORR:    state_next = tspc_pkg::ST_INTEG;
      tspc_pkg::ST_INTEG:   state_next = tspc_pkg::ST_MUL_KP;
      tspc_pkg::ST_MUL_KP:  state_next = tspc_pkg::ST_MUL_KIL;
      tspc_pkg::ST_MUL_KIL: state_next = tspc_pkg::ST_MUL_KIH;
      tspc_pkg::ST_MUL_KIH: state_next = tspc_pkg::ST_SUM;
      tspc_pkg::ST_SUM:     state_next = tspc_pkg::ST_CLAMP;
      tspc_pkg::ST_CLAMP:   if (!status.out_busy) state_next = tspc_pkg::ST_IDLE;
      default:              state_next = tspc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.op       = tspc_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      tspc_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      tspc_pkg::ST_MUL_T:   cmd.op = tspc_pkg::OP_MUL_T;
      tspc_pkg::ST_MUL_A:   cmd.op = tspc_pkg::OP_MUL_A;
      tspc_pkg::ST_ERR:     cmd.op = tspc_pkg::OP_ERR;
      tspc_pkg::ST_MUL_PER: cmd.op = tspc_pkg::OP_MUL_PER;
      tspc_pkg::ST_MUL_REC: cmd.op = tspc_pkg::OP_MUL_REC;
      tspc_pkg::ST_CORR:    cmd.op = tspc_pkg::OP_CORR;
      tspc_pkg::ST_INTEG:   cmd.op = tspc_pkg::OP_INTEG;
      tspc_pkg::ST_MUL_KP:  cmd.op = tspc_pkg::OP_MUL_KP;
      tspc_pkg::ST_MUL_KIL: cmd.op = tspc_pkg::OP_MUL_KIL;
      tspc_pkg::ST_MUL_KIH: cmd.op = tspc_pkg::OP_MUL_KIH;
      tspc_pkg::ST_SUM:     cmd.op = tspc_pkg::OP_SUM;
      tspc_pkg::ST_CLAMP: begin
        cmd.op       = tspc_pkg::OP_CLAMP;
        cmd.out_load = ~status.out_busy;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/train_speed_pi_power_controller.sv =====
// top level of the train speed pi power controller with station-stop door logic
// depends on tspc_pkg, tspc_ctrl and tspc_datapath
//
//   channel  handshake               payload
//   in       in_valid / in_ready     target_speed, actual_speed, authority,
//                                    stop_request, door_side
//   out      out_valid / out_ready   power_watts, left_open, right_open
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// the sequencer steps from idle through mul_t to clamp after each input beat, loads the
// result in clamp and takes the next input beat only once back in idle: the multiplies
// of a tick (two speed conversions, period scaling, divide-by-2000 reciprocal and three
// gain products) run in turn through one 33x32 multiplier.
// synchronous reset clears the sequencer, controller state and config registers (period_ms to 100).
// a full result register stalls the sequencer in its last step; cfg is always ready.
module train_speed_pi_power_controller #(
  parameter int unsigned POWER_LIMIT    = tspc_pkg::DEF_POWER_LIMIT,
  parameter int unsigned GAIN_FRAC_BITS = tspc_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tspc_pkg::SPEED_W-1:0]  target_speed,
  input  logic [tspc_pkg::SPEED_W-1:0]  actual_speed,
  input  logic [tspc_pkg::SPEED_W-1:0]  authority,
  input  logic                          stop_request,
  input  logic [1:0]                    door_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tspc_pkg::POWER_W-1:0]  power_watts,
  output logic                          left_open,
  output logic                          right_open,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [tspc_pkg::GAIN_W-1:0]   cfg_data
);

  tspc_pkg::cmd_t    cmd;
  tspc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  tspc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  tspc_datapath #(
    .POWER_LIMIT    (POWER_LIMIT),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .target_speed (target_speed),
    .actual_speed (actual_speed),
    .authority    (authority),
    .stop_request (stop_request),
    .door_side    (door_side),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .power_watts  (power_watts),
    .left_open    (left_open),
    .right_open   (right_open)
  );

endmodule

// ===== tb/tb_train_speed_pi_power_controller.sv =====
// testbench for train_speed_pi_power_controller: drives control ticks, predicts
// power and door state per tick and checks every result beat in order
// depends on tspc_pkg and the train_speed_pi_power_controller rtl
`timescale 1ns / 1ps

module tb_train_speed_pi_power_controller;

  localparam int unsigned PWR_LIMIT  = tspc_pkg::DEF_POWER_LIMIT;
  localparam int unsigned PWR_SHIFT  = tspc_pkg::DEF_GAIN_FRAC_BITS + 8;
  localparam longint      INTEG_SAT  = (longint'(1) <<< 47) - 1;
  localparam int          STALL_LIMIT = 3000;
  localparam int          LONG_HOLD   = 300;

  typedef struct packed {
    logic [15:0] target;
    logic [15:0] actual;
    logic [15:0] auth;
    logic        stop;
    logic [1:0]  side;
  } tick_t;

  typedef struct packed {
    logic [16:0] power;
    logic        left_open;
    logic        right_open;
  } power_cmd_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] target_speed;
  logic [15:0] actual_speed;
  logic [15:0] authority;
  logic        stop_request;
  logic [1:0]  door_side;
  logic        out_valid;
  logic        out_ready;
  logic [16:0] power_watts;
  logic        left_open;
  logic        right_open;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  train_speed_pi_power_controller dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .target_speed (target_speed),
    .actual_speed (actual_speed),
    .authority    (authority),
    .stop_request (stop_request),
    .door_side    (door_side),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .power_watts  (power_watts),
    .left_open    (left_open),
    .right_open   (right_open),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // controller mirror: registers and tick state
  logic [31:0] kp_cfg;
  logic [31:0] ki_cfg;
  logic [15:0] period_cfg;
  longint      prev_err;
  longint      integ;
  logic        stop_latched;
  logic        left_door;
  logic        right_door;

  tick_t      tick_queue[$];
  power_cmd_t power_cmd_q[$];
  int         ticks_queued;
  int         ticks_taken;
  int         mismatches;
  int         quiet_cycles;
  logic       in_beat;
  logic       bursts_on;
  logic       hold_req;
  int         hold_left;
  int         rx_stall;
  int         tx_gap;
  tick_t      tx_tick;
  tick_t      rx_tick;
  power_cmd_t want;

  // q8.8 mph to q8.8 kph, round half up
  function automatic longint mph_to_kph(logic [15:0] mph);
    return (longint'(mph) * longint'(tspc_pkg::KPH_PER_MPH) + 32768) >>> 16;
  endfunction

  // one control tick: integrator, doors, gains and clamps
  function automatic power_cmd_t predict_power_cmd(tick_t tk);
    longint err;
    longint sum;
    longint mag;
    longint acc;
    logic signed [127:0] e_w;
    logic signed [127:0] i_w;
    logic signed [127:0] kp_w;
    logic signed [127:0] ki_w;
    logic signed [127:0] total;
    logic signed [127:0] thresh;
    power_cmd_t r;
    if (tk.stop) stop_latched = 1'b1;
    err = mph_to_kph(tk.target) - mph_to_kph(tk.actual);
    sum = err + prev_err;
    mag = (sum < 0) ? -sum : sum;
    mag = (mag * longint'(period_cfg)) / 2000;
    acc = integ + ((sum < 0) ? -mag : mag);
    if (acc > INTEG_SAT) acc = INTEG_SAT;
    if (acc < -INTEG_SAT) acc = -INTEG_SAT;
    integ = acc;
    prev_err = err;
    // station stop opens doors only once standing
    if (tk.actual == 16'd0 && stop_latched) begin
      if (tk.side[0]) left_door = 1'b1;
      if (tk.side[1]) right_door = 1'b1;
      stop_latched = 1'b0;
    end
    if (tk.actual != 16'd0) begin
      left_door = 1'b0;
      right_door = 1'b0;
    end
    e_w = err;
    i_w = integ;
    kp_w = {96'd0, kp_cfg};
    ki_w = {96'd0, ki_cfg};
    total = e_w * kp_w + i_w * ki_w;
    thresh = PWR_LIMIT + 1;
    thresh = thresh <<< PWR_SHIFT;
    if (total < 0) begin
      r.power = '0;
      integ = 0;
    end else if (total >= thresh) begin
      r.power = 17'(PWR_LIMIT);
      integ = longint'(PWR_LIMIT) <<< 8;
    end else begin
      r.power = 17'(total >>> PWR_SHIFT);
    end
    if (tk.auth == 16'd0) begin
      r.power = '0;
      integ = 0;
    end
    r.left_open = left_door;
    r.right_open = right_door;
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // input driver: next tick from the queue once the current beat is taken, with random gaps while bursts are on
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (tick_queue.size() > 0) begin
        tx_tick = tick_queue.pop_front();
        target_speed <= tx_tick.target;
        actual_speed <= tx_tick.actual;
        authority <= tx_tick.auth;
        stop_request <= tx_tick.stop;
        door_side <= tx_tick.side;
        in_valid <= 1'b1;
        if (bursts_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stall bursts and one long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (bursts_on && $urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 8);
    end
  end

  // monitor: register writes, tick beats, result beats and the watchdog
  always @(posedge clk) begin
    in_beat = 1'b0;
    if (!rst) begin
      in_beat = in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        case (tspc_pkg::reg_idx_t'(cfg_index))
          tspc_pkg::REG_PROP_GAIN:  kp_cfg = cfg_data;
          tspc_pkg::REG_INTEG_GAIN: ki_cfg = cfg_data;
          tspc_pkg::REG_PERIOD_MS:  period_cfg = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_beat) begin
        rx_tick.target = target_speed;
        rx_tick.actual = actual_speed;
        rx_tick.auth = authority;
        rx_tick.stop = stop_request;
        rx_tick.side = door_side;
        power_cmd_q.push_back(predict_power_cmd(rx_tick));
        ticks_taken++;
      end
      if (out_valid && out_ready) begin
        if (power_cmd_q.size() == 0) begin
          $error("result beat with no tick outstanding: power_watts %0d", power_watts);
          mismatches++;
        end else begin
          want = power_cmd_q.pop_front();
          if (power_watts !== want.power) begin
            $error("power_watts: expected %0d, actual %0d", want.power, power_watts);
            mismatches++;
          end
          if (left_open !== want.left_open) begin
            $error("left_open: expected %0d, actual %0d", want.left_open, left_open);
            mismatches++;
          end
          if (right_open !== want.right_open) begin
            $error("right_open: expected %0d, actual %0d", want.right_open, right_open);
            mismatches++;
          end
        end
      end
      if (in_beat || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(tspc_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_gains(logic [31:0] kp, logic [31:0] ki, logic [15:0] per);
    write_reg(tspc_pkg::REG_PROP_GAIN, kp);
    write_reg(tspc_pkg::REG_INTEG_GAIN, ki);
    write_reg(tspc_pkg::REG_PERIOD_MS, {16'd0, per});
  endtask

  // wait until every tick is taken and answered, then let the sequencer settle
  task automatic drain(int settle);
    while (ticks_taken != ticks_queued || power_cmd_q.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic push_tick(logic [15:0] tgt, logic [15:0] act, logic [15:0] auth,
                           logic stop, logic [1:0] side);
    tick_t tk;
    tk.target = tgt;
    tk.actual = act;
    tk.auth = auth;
    tk.stop = stop;
    tk.side = side;
    tick_queue.push_back(tk);
    ticks_queued++;
  endtask

  // mostly plausible driving ticks near the set speed, some full-range noise
  task automatic push_random(int n);
    int tgt;
    int act;
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) begin
        tgt = $urandom_range(0, 20000);
        if ($urandom_range(0, 6) == 0) act = 0;
        else act = tgt + $urandom_range(0, 3000) - 1500;
        if (act < 0) act = 0;
        push_tick(16'(tgt), 16'(act),
                  ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
                  $urandom_range(0, 9) == 0, 2'($urandom_range(0, 3)));
      end else begin
        push_tick(16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom), 2'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    target_speed = '0;
    actual_speed = '0;
    authority = '0;
    stop_request = 1'b0;
    door_side = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    kp_cfg = '0;
    ki_cfg = '0;
    period_cfg = tspc_pkg::PERIOD_RESET;
    prev_err = 0;
    integ = 0;
    stop_latched = 1'b0;
    left_door = 1'b0;
    right_door = 1'b0;
    ticks_queued = 0;
    ticks_taken = 0;
    mismatches = 0;
    quiet_cycles = 0;
    in_beat = 1'b0;
    bursts_on = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    rx_stall = 0;
    tx_gap = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: zero gains, stop latched and both doors opened, then closed
    push_tick(16'd0, 16'd0, 16'd0, 1'b0, 2'd0);
    push_tick(16'hFFFF, 16'd0, 16'hFFFF, 1'b1, 2'd3);
    push_tick(16'hFFFF, 16'hFFFF, 16'd1, 1'b0, 2'd0);
    drain(16);

    // moderate gains: each door side, clamps both ways, zero authority
    set_gains(32'd1000 << 16, 32'd50 << 16, 16'd100);
    push_tick(16'd100, 16'd100, 16'd500, 1'b1, 2'd1);
    push_tick(16'd0, 16'd0, 16'd500, 1'b0, 2'd1);
    push_tick(16'd0, 16'd0, 16'd500, 1'b1, 2'd2);
    push_tick(16'd0, 16'd0, 16'd500, 1'b1, 2'd0);
    push_tick(16'd0, 16'd0, 16'd500, 1'b0, 2'd3);
    push_tick(16'd0, 16'd1, 16'd500, 1'b0, 2'd3);
    push_tick(16'hFFFF, 16'd0, 16'hFFFF, 1'b0, 2'd0);
    push_tick(16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 2'd0);
    push_tick(16'd5000, 16'd4000, 16'd0, 1'b0, 2'd0);
    push_tick(16'd5000, 16'd4000, 16'd1, 1'b0, 2'd0);
    push_tick(16'd4000, 16'd5000, 16'd1, 1'b0, 2'd0);
    drain(16);

    // proportional only, tuned so 10 kph error gives exactly the power limit
    set_gains(32'd786432000, 32'd0, 16'hFFFF);
    push_tick(16'd1591, 16'd0, 16'd1000, 1'b0, 2'd0);
    push_tick(16'd1592, 16'd0, 16'd1000, 1'b0, 2'd0);
    push_tick(16'd1590, 16'd0, 16'd1000, 1'b0, 2'd0);
    drain(16);

    // zero period: the integrate step adds nothing to the integrator
    write_reg(tspc_pkg::REG_INTEG_GAIN, 32'd1 << 16);
    write_reg(tspc_pkg::REG_PERIOD_MS, 32'd0);
    push_tick(16'd3000, 16'd1000, 16'd100, 1'b0, 2'd0);
    push_tick(16'd3000, 16'd1000, 16'd100, 1'b0, 2'd0);
    drain(16);

    // typical tuning, opened with a long receiver hold so the block backs up
    set_gains(32'($urandom_range(200, 2000)) << 16, 32'($urandom_range(10, 300)) << 16,
              16'($urandom_range(20, 500)));
    hold_req = 1'b1;
    push_random(250);
    drain(16);

    // largest gains and period
    set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_random(100);
    drain(16);

    // integral only, shortest period, sender pauses halfway until all results are in
    set_gains(32'd0, 32'($urandom_range(1, 1000)) << 16, 16'd1);
    push_random(50);
    drain(0);
    push_random(50);
    drain(16);

    // arbitrary register values
    set_gains($urandom, $urandom, 16'($urandom_range(1, 65535)));
    push_random(100);
    drain(16);

    set_gains(32'($urandom_range(100, 3000)) << 16, 32'($urandom_range(1, 100)) << 16,
              16'd100);
    push_random(200);
    drain(16);

    // closing stretch at full rate on both sides
    bursts_on = 1'b0;
    set_gains(32'($urandom_range(200, 1500)) << 16, 32'($urandom_range(5, 200)) << 16,
              16'($urandom_range(50, 250)));
    push_random(150);
    drain(30);

    if (mismatches == 0 && power_cmd_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tspc_pkg.sv
sv/tspc_datapath.sv
sv/tspc_ctrl.sv
sv/train_speed_pi_power_controller.sv
tb/tb_train_speed_pi_power_controller.sv
